// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/bso_pkg.sv
`timescale 1ns / 1ps

package bso_pkg;

    // register file layout
    localparam int REG_W       = 48;
    localparam int NUM_AXES    = 3;
    localparam int CFG_INDEX_W = 3;

    // axis components are signed q1.14, 16 bits each
    localparam int AXIS_W      = 16;
    localparam int FRAC_SHIFT  = 14;
    localparam int RADSQ_SHIFT = 2 * FRAC_SHIFT;

    // lane covers projection through squared excess
    localparam int LANE_STAGES = 6;
    localparam int PIPE_DEPTH  = LANE_STAGES + 3;

    localparam logic [REG_W-1:0] AXIS_U_RESET = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] AXIS_V_RESET = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] AXIS_W_RESET = 48'h4000_0000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER  = 3'd0,
        CFG_AXIS_U  = 3'd1,
        CFG_AXIS_V  = 3'd2,
        CFG_AXIS_W  = 3'd3,
        CFG_EXTENTS = 3'd4
    } cfg_index_t;

endpackage

// File: rtl/bso_axis_lane.sv
`timescale 1ns / 1ps

module bso_axis_lane
    import bso_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic signed [COORD_BITS:0]                diff [NUM_AXES],
    input  logic [REG_W-1:0]                          axis,
    input  logic [COORD_BITS-1:0]                     extent,
    output logic [2*(COORD_BITS+AXIS_W+1)-1:0]        sq
);

    localparam int PROD_W = COORD_BITS + AXIS_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int D_W    = PROD_W;
    localparam int H      = (D_W + 1) / 2;
    localparam int HI_W   = D_W - H;
    localparam int SQ_W   = 2 * D_W;

    logic signed [PROD_W-1:0] prod_reg [NUM_AXES];
    logic signed [PROD_W-1:0] prod_next [NUM_AXES];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [D_W-1:0]           abs_reg;
    logic [D_W-1:0]           abs_next;
    logic [D_W-1:0]           ext_q22;
    logic [D_W-1:0]           d_reg;
    logic [D_W-1:0]           d_next;
    logic [HI_W-1:0]          d_hi;
    logic [H-1:0]             d_lo;
    logic [2*HI_W-1:0]        hh_reg;
    logic [2*HI_W-1:0]        hh_next;
    logic [D_W-1:0]           hl_reg;
    logic [D_W-1:0]           hl_next;
    logic [2*H-1:0]           ll_reg;
    logic [2*H-1:0]           ll_next;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sq_next;

    // one signed product per coordinate
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            prod_next[k] = diff[k] * $signed(axis[k*AXIS_W +: AXIS_W]);
        end
    end

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);
    assign abs_next = sum_reg[SUM_W-1] ? D_W'(-sum_reg) : D_W'(sum_reg);

    // excess beyond the half-extent, zero when inside the slab
    assign ext_q22 = D_W'({extent, {FRAC_SHIFT{1'b0}}});
    assign d_next  = (abs_reg > ext_q22) ? (abs_reg - ext_q22) : '0;

    // square split into half-width partial products
    assign d_hi    = d_reg[D_W-1:H];
    assign d_lo    = d_reg[H-1:0];
    assign hh_next = d_hi * d_hi;
    assign hl_next = d_hi * d_lo;
    assign ll_next = d_lo * d_lo;

    assign sq_next = (SQ_W'(hh_reg) << (2 * H)) + (SQ_W'(hl_reg) << (H + 1)) + SQ_W'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            abs_reg  <= abs_next;
            d_reg    <= d_next;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            sq_reg   <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

// File: rtl/box_sphere_overlap_test_core.sv
// Oriented box versus sphere overlap test. Program the box through the
// configuration port (index 0 center, 1..3 axes u/v/w in signed q1.14, 4 the
// half-extents, three fields per 48-bit word with x lowest; other indexes are
// ignored), then stream spheres: one request per clock is accepted and each
// gives one intersects bit, 1 when the sphere touches or overlaps the box.
// Nine register stages, with out_valid carried through a valid shift register
// alongside the data; the rate is one sphere per clock, set by the single
// pipeline that advances whenever the output register is empty or being
// taken. A stall on out_ready freezes the whole pipeline. Axes are used as
// given, without normalization, and all math is exact. Write the
// configuration only when no request is in flight.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module box_sphere_overlap_test_core
    import bso_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [REG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  sphere_x,
    input  logic signed [COORD_BITS-1:0]  sphere_y,
    input  logic signed [COORD_BITS-1:0]  sphere_z,
    input  logic [COORD_BITS-1:0]         sphere_radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          intersects
);

    localparam int FIELD_SPAN = NUM_AXES * COORD_BITS;
    // fields beyond the 48-bit register read as zero for wide coordinates
    localparam int PAD_W      = (FIELD_SPAN > REG_W) ? FIELD_SPAN : REG_W;
    localparam int SQ_W       = 2 * (COORD_BITS + AXIS_W + 1);
    localparam int DIST_W     = SQ_W + 2;
    localparam int R2_W       = 2 * COORD_BITS;

    // box configuration
    logic [REG_W-1:0] center_reg;
    logic [REG_W-1:0] axis_u_reg;
    logic [REG_W-1:0] axis_v_reg;
    logic [REG_W-1:0] axis_w_reg;
    logic [REG_W-1:0] extents_reg;
    logic [REG_W-1:0] axis_sel [NUM_AXES];
    logic [PAD_W-1:0] center_pad;
    logic [PAD_W-1:0] extents_pad;

    // pipeline control
    logic                  en;
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] v_next;

    // stage 1: offset from box center
    logic signed [COORD_BITS-1:0] sphere_pos [NUM_AXES];
    logic signed [COORD_BITS:0]   diff_reg [NUM_AXES];
    logic signed [COORD_BITS:0]   diff_next [NUM_AXES];
    logic [COORD_BITS-1:0]        radius_reg;

    // radius square delayed alongside the axis lanes
    logic [R2_W-1:0] r2_reg [LANE_STAGES];

    // lane results and final stages
    logic [SQ_W-1:0]   sq [NUM_AXES];
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    logic [DIST_W-1:0] rad_sq_reg;
    logic              intersects_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= '0;
            axis_u_reg  <= AXIS_U_RESET;
            axis_v_reg  <= AXIS_V_RESET;
            axis_w_reg  <= AXIS_W_RESET;
            extents_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTER:  center_reg  <= cfg_data;
                CFG_AXIS_U:  axis_u_reg  <= cfg_data;
                CFG_AXIS_V:  axis_v_reg  <= cfg_data;
                CFG_AXIS_W:  axis_w_reg  <= cfg_data;
                CFG_EXTENTS: extents_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign center_pad  = PAD_W'(center_reg);
    assign extents_pad = PAD_W'(extents_reg);
    assign axis_sel[0] = axis_u_reg;
    assign axis_sel[1] = axis_v_reg;
    assign axis_sel[2] = axis_w_reg;

    // whole pipeline moves when the output register is free or being taken
    assign en       = !v_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready = en;
    assign v_next   = {v_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    assign sphere_pos[0] = sphere_x;
    assign sphere_pos[1] = sphere_y;
    assign sphere_pos[2] = sphere_z;

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            diff_next[k] = $signed({sphere_pos[k][COORD_BITS-1], sphere_pos[k]})
                - $signed({center_pad[k*COORD_BITS + COORD_BITS - 1],
                           center_pad[k*COORD_BITS +: COORD_BITS]});
        end
    end

    // sum of squared excesses; inside axes contribute zero, so a single
    // face excess and the edge/corner cases reduce to the same compare
    assign dist_next = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg   <= diff_next;
            radius_reg <= sphere_radius;
            r2_reg[0]  <= radius_reg * radius_reg;
            for (int i = 1; i < LANE_STAGES; i++)
            begin
                r2_reg[i] <= r2_reg[i-1];
            end
            dist_reg       <= dist_next;
            rad_sq_reg     <= DIST_W'(r2_reg[LANE_STAGES-1]) << RADSQ_SHIFT;
            // touching counts as intersecting
            intersects_reg <= (dist_reg <= rad_sq_reg);
        end
    end

    // one lane per box axis: projection, abs, excess, square
    for (genvar j = 0; j < NUM_AXES; j++)
    begin : g_lane
        bso_axis_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (en),
            .diff   (diff_reg),
            .axis   (axis_sel[j]),
            .extent (extents_pad[j*COORD_BITS +: COORD_BITS]),
            .sq     (sq[j])
        );
    end

    assign out_valid  = v_reg[PIPE_DEPTH-1];
    assign intersects = intersects_reg;

    // a stalled output freezes every stage
    `ASSERT_NEXT(a_stall_freezes, clk, rst_n, out_valid && !out_ready, $stable(v_reg))
    // an accepted request lands in the first stage
    `ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, v_reg[0])
    // a new result only comes from the stage before the output
    `ASSERT_IMPLIES(a_out_source, clk, rst_n, $rose(out_valid), $past(v_reg[PIPE_DEPTH-2]))
    // no excess on any axis always gives a hit
    `ASSERT_NEXT(a_inside_hits, clk, rst_n, en && v_reg[PIPE_DEPTH-2] && (dist_reg == '0),
                 intersects)

endmodule
